@@ design/owmm_pkg.sv @@
package owmm_pkg;

	// Fixed field and register widths.
	localparam int CODE_WIDTH = 12;
	localparam int VEL_W = 16;
	localparam int NEUTRAL_W = 12;
	localparam int GAIN_W = 10;
	localparam int LIMIT_W = 3;
	localparam int OFFSET_W = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 12;

	// Gain times a limit of at most four units.
	localparam int GLIM_W = GAIN_W + 2;

	// Wheel count and command axes.
	localparam int LANES = 4;
	localparam int AXES = 3;

	// Divider geometry: quotient bits, bits resolved per stage, stage count.
	localparam int QUO_W = 12;
	localparam int DIV_STEP = 3;
	localparam int DIV_STAGES = QUO_W / DIV_STEP;

	// Unscaled rounded wheel term and the signed width of the code arithmetic.
	localparam int QLIN_W = 13;
	localparam int CODE_CALC_W = (CODE_WIDTH + 2 > 15) ? CODE_WIDTH + 2 : 15;

	// Operation codes.
	localparam logic OP_VELOCITY = 1'b0;
	localparam logic OP_STOP = 1'b1;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NEUTRAL = 3'd0,
		REG_GAIN    = 3'd1,
		REG_LIMIT   = 3'd2,
		REG_OFFSET  = 3'd3,
		REG_HALT    = 3'd4
	} reg_index_t;

	// Register reset values.
	localparam logic [NEUTRAL_W-1:0] NEUTRAL_RESET = NEUTRAL_W'(1500);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(100);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2);
	localparam logic HALT_RESET = 1'b0;

	// Usable range of the combined limit.
	localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(1);
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(4);

	// Sign matrix: bit k set means axis k (forward, sideways, rotation) is subtracted.
	localparam logic [AXES-1:0] MIX_NEG [LANES] = '{3'b110, 3'b100, 3'b000, 3'b010};

	typedef struct packed {
		logic operation;
		logic signed [VEL_W-1:0] vel_forward;
		logic signed [VEL_W-1:0] vel_sideways;
		logic signed [VEL_W-1:0] vel_rotation;
	} cmd_t;

	typedef struct packed {
		logic [CODE_WIDTH-1:0] motor_rear_right;
		logic [CODE_WIDTH-1:0] motor_front_right;
		logic [CODE_WIDTH-1:0] motor_rear_left;
		logic [CODE_WIDTH-1:0] motor_front_left;
	} res_t;

	// Configuration as seen by the pipeline; limit is already brought into range.
	typedef struct packed {
		logic [NEUTRAL_W-1:0] neutral;
		logic [GAIN_W-1:0] gain;
		logic [LIMIT_W-1:0] limit;
		logic [OFFSET_W-1:0] offset;
		logic [GLIM_W-1:0] glim;
		logic halted;
	} cfg_t;

	// Per-item flags and unscaled wheel terms riding alongside the divider.
	typedef struct packed {
		logic op;
		logic scale;
		logic [LANES-1:0][QLIN_W-1:0] qlin;
	} side_t;

endpackage

@@ design/owmm_mix.sv @@
module owmm_mix #(
	parameter int FRAC_BITS = 14,
	localparam int WW = FRAC_BITS + 3,
	localparam int AW = FRAC_BITS + 2
) (
	input  logic clk,
	input  logic arst_n,
	input  owmm_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  owmm_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic op,
	output logic scale,
	output logic [AW-1:0] amp,
	output logic signed [WW-1:0] w [owmm_pkg::LANES]
);

	localparam int VW = FRAC_BITS + 2;
	localparam int EW = (VW > owmm_pkg::VEL_W + 1) ? VW : owmm_pkg::VEL_W + 1;
	localparam int ONE = 1 << FRAC_BITS;
	localparam logic signed [EW-1:0] ONE_E = EW'(ONE);

	function automatic logic signed [VW-1:0] clamp_unit(input logic signed [owmm_pkg::VEL_W-1:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		if (e > ONE_E) begin
			e = ONE_E;
		end else if (e < -ONE_E) begin
			e = -ONE_E;
		end
		return e[VW-1:0];
	endfunction

	logic v_s1, v_s2;
	logic en1, en2;
	logic op_s1, op_s2;
	logic signed [WW-1:0] w_s1 [owmm_pkg::LANES];
	logic signed [WW-1:0] w_s2 [owmm_pkg::LANES];
	logic [AW-1:0] abs_s1 [owmm_pkg::LANES];
	logic [AW-1:0] amp_s2;
	logic scale_s2;

	logic signed [VW-1:0] vel [owmm_pkg::AXES];
	logic signed [WW-1:0] wsum [owmm_pkg::LANES];
	logic [AW-1:0] wabs [owmm_pkg::LANES];
	logic [AW-1:0] max_a, max_b, amp_c;
	logic [AW:0] lim_one;
	logic scale_c;

	// Stage one: clamp the three axes, mix them into wheel speeds, take magnitudes.
	always_comb begin
		logic signed [WW-1:0] acc;
		vel[0] = clamp_unit(cmd.vel_forward);
		vel[1] = clamp_unit(cmd.vel_sideways);
		vel[2] = clamp_unit(cmd.vel_rotation);
		for (int i = 0; i < owmm_pkg::LANES; i++) begin
			acc = '0;
			for (int k = 0; k < owmm_pkg::AXES; k++) begin
				if (owmm_pkg::MIX_NEG[i][k]) begin
					acc = acc - WW'(vel[k]);
				end else begin
					acc = acc + WW'(vel[k]);
				end
			end
			wsum[i] = acc;
			wabs[i] = (acc < 0) ? AW'(-acc) : AW'(acc);
		end
	end

	// Stage two: largest magnitude and whether it exceeds the limit.
	always_comb begin
		max_a = (abs_s1[0] > abs_s1[1]) ? abs_s1[0] : abs_s1[1];
		max_b = (abs_s1[2] > abs_s1[3]) ? abs_s1[2] : abs_s1[3];
		amp_c = (max_a > max_b) ? max_a : max_b;
		lim_one = (AW + 1)'(cfg.limit) << FRAC_BITS;
		scale_c = {1'b0, amp_c} > lim_one;
	end

	// Stage enables: a stage loads when empty or when its successor moves.
	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// Valid bits; a velocity command while halted is taken but dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid && (cmd.operation == owmm_pkg::OP_STOP || !cfg.halted);
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= cmd.operation;
			w_s1 <= wsum;
			abs_s1 <= wabs;
		end
		if (en2) begin
			op_s2 <= op_s1;
			w_s2 <= w_s1;
			amp_s2 <= amp_c;
			scale_s2 <= scale_c;
		end
	end

	assign out_valid = v_s2;
	assign op = op_s2;
	assign scale = scale_s2;
	assign amp = amp_s2;
	assign w = w_s2;

	// Scaling only happens for a largest magnitude above one unit and at most three.
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && scale_s2 |-> (amp_s2 > ONE) && (amp_s2 <= 3 * ONE))
		else $error("scale flag set for an out of range wheel magnitude");

endmodule

@@ design/owmm_scale.sv @@
module owmm_scale #(
	parameter int FRAC_BITS = 14,
	localparam int WW = FRAC_BITS + 3,
	localparam int AW = FRAC_BITS + 2,
	localparam int DW = FRAC_BITS + 3,
	localparam int NW = DW + owmm_pkg::QUO_W
) (
	input  logic clk,
	input  logic arst_n,
	input  owmm_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic scale,
	input  logic [AW-1:0] amp,
	input  logic signed [WW-1:0] w [owmm_pkg::LANES],
	output logic out_valid,
	input  logic out_ready,
	output logic [NW-1:0] num [owmm_pkg::LANES],
	output logic [DW-1:0] den,
	output owmm_pkg::side_t side
);

	localparam int BW = WW + 1;
	localparam int PW = owmm_pkg::GLIM_W + 1 + BW;
	localparam int HALF = 1 << (FRAC_BITS - 1);

	logic v_s3;
	logic en3;
	logic [NW-1:0] num_s3 [owmm_pkg::LANES];
	logic [DW-1:0] den_s3;
	owmm_pkg::side_t side_s3;

	logic [NW-1:0] num_c [owmm_pkg::LANES];
	owmm_pkg::side_t side_c;

	// One multiplier per wheel. Scaled items form the offset dividend
	// 2*G*(w + amp) + amp, whose quotient by 2*amp minus G is the rounded term.
	// Unscaled items round gain*w to whole codes by a shift.
	always_comb begin
		logic [owmm_pkg::GLIM_W-1:0] a_op;
		logic signed [BW-1:0] b_op;
		logic signed [BW-1:0] amp_ext;
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] num_full;
		logic signed [PW-1:0] lin;
		amp_ext = $signed({2'b00, amp});
		side_c.op = op;
		side_c.scale = scale;
		for (int i = 0; i < owmm_pkg::LANES; i++) begin
			a_op = scale ? cfg.glim : owmm_pkg::GLIM_W'(cfg.gain);
			b_op = scale ? (BW'(w[i]) + amp_ext) : BW'(w[i]);
			prod = $signed({1'b0, a_op}) * b_op;
			num_full = (prod <<< 1) + PW'(amp_ext);
			num_c[i] = num_full[NW-1:0];
			lin = (prod + PW'(HALF)) >>> FRAC_BITS;
			side_c.qlin[i] = lin[owmm_pkg::QLIN_W-1:0];
		end
	end

	assign en3 = !v_s3 || out_ready;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			num_s3 <= num_c;
			den_s3 <= {amp, 1'b0};
			side_s3 <= side_c;
		end
	end

	assign out_valid = v_s3;
	assign num = num_s3;
	assign den = den_s3;
	assign side = side_s3;

	// A scaled item never hands the divider a zero divisor.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && side_s3.scale |-> den_s3 != '0)
		else $error("zero divisor on a scaled item");

endmodule

@@ design/owmm_div.sv @@
module owmm_div #(
	parameter int FRAC_BITS = 14,
	localparam int DW = FRAC_BITS + 3,
	localparam int NW = DW + owmm_pkg::QUO_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [NW-1:0] num [owmm_pkg::LANES],
	input  logic [DW-1:0] den,
	input  owmm_pkg::side_t side_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [owmm_pkg::QUO_W-1:0] quo [owmm_pkg::LANES],
	output owmm_pkg::side_t side_out
);

	localparam int NS = owmm_pkg::DIV_STAGES;
	localparam int QW = owmm_pkg::QUO_W;

	// Per stage: partial remainder, and a word that shifts dividend bits out
	// at the top while quotient bits enter at the bottom.
	logic v_s [NS];
	logic en [NS];
	logic [DW-1:0] rem_s [NS][owmm_pkg::LANES];
	logic [QW-1:0] lo_s [NS][owmm_pkg::LANES];
	logic [DW-1:0] den_s [NS];
	owmm_pkg::side_t side_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic v_in;
		logic [DW-1:0] rem_in [owmm_pkg::LANES];
		logic [QW-1:0] lo_in [owmm_pkg::LANES];
		logic [DW-1:0] den_in;
		owmm_pkg::side_t side_k;
		logic [DW-1:0] rem_nx [owmm_pkg::LANES];
		logic [QW-1:0] lo_nx [owmm_pkg::LANES];

		// Stage inputs come from the module ports or the previous stage.
		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign den_in = den;
			assign side_k = side_in;
			for (genvar l = 0; l < owmm_pkg::LANES; l++) begin : g_lane
				assign rem_in[l] = num[l][NW-1:QW];
				assign lo_in[l] = num[l][QW-1:0];
			end
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign den_in = den_s[k-1];
			assign side_k = side_s[k-1];
			assign rem_in = rem_s[k-1];
			assign lo_in = lo_s[k-1];
		end

		if (k == NS - 1) begin : g_last_en
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid_en
			assign en[k] = !v_s[k] || en[k+1];
		end

		// Restoring division, a few quotient bits per stage.
		always_comb begin
			logic [DW-1:0] r;
			logic [QW-1:0] q;
			logic [DW:0] t;
			logic [DW:0] diff;
			logic ge;
			for (int l = 0; l < owmm_pkg::LANES; l++) begin
				r = rem_in[l];
				q = lo_in[l];
				for (int j = 0; j < owmm_pkg::DIV_STEP; j++) begin
					t = {r, q[QW-1]};
					diff = t - {1'b0, den_in};
					ge = t >= {1'b0, den_in};
					q = {q[QW-2:0], ge};
					r = ge ? diff[DW-1:0] : t[DW-1:0];
				end
				rem_nx[l] = r;
				lo_nx[l] = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_nx;
				lo_s[k] <= lo_nx;
				den_s[k] <= den_in;
				side_s[k] <= side_k;
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = v_s[NS-1];
	assign quo = lo_s[NS-1];
	assign side_out = side_s[NS-1];

	// A held first stage keeps its item and divisor while the pipe ahead is blocked.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && !en[0] |=> v_s[0] && $stable(den_s[0]))
		else $error("divider stage lost its item during a stall");

endmodule

@@ design/owmm_code.sv @@
module owmm_code (
	input  logic clk,
	input  logic arst_n,
	input  owmm_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [owmm_pkg::QUO_W-1:0] quo [owmm_pkg::LANES],
	input  owmm_pkg::side_t side,
	output logic out_valid,
	input  logic out_ready,
	output owmm_pkg::res_t res
);

	localparam int CW = owmm_pkg::CODE_CALC_W;
	localparam logic signed [CW-1:0] TOP = CW'((1 << owmm_pkg::CODE_WIDTH) - 1);

	logic v_s8;
	logic en8;
	logic op_s8;
	owmm_pkg::res_t res_s8;

	logic [owmm_pkg::CODE_WIDTH-1:0] code_c [owmm_pkg::LANES];
	owmm_pkg::res_t res_c;

	// Offset and clamp around neutral, force neutral for a stop, then saturate to the code range.
	always_comb begin
		logic signed [CW-1:0] neu;
		logic signed [CW-1:0] glim_s;
		logic signed [CW-1:0] back_s;
		logic signed [CW-1:0] lo_lim;
		logic signed [CW-1:0] hi_lim;
		logic signed [CW-1:0] q;
		logic signed [CW-1:0] c;
		neu = CW'(cfg.neutral);
		glim_s = CW'(cfg.glim);
		back_s = CW'(cfg.offset);
		lo_lim = neu - glim_s - back_s;
		hi_lim = neu + glim_s;
		for (int i = 0; i < owmm_pkg::LANES; i++) begin
			if (side.scale) begin
				q = CW'(quo[i]) - glim_s;
			end else begin
				q = CW'($signed(side.qlin[i]));
			end
			c = neu + q;
			if (q < 0) begin
				c = c - back_s;
			end
			if (c < lo_lim) begin
				c = lo_lim;
			end
			if (c > hi_lim) begin
				c = hi_lim;
			end
			if (side.op == owmm_pkg::OP_STOP) begin
				c = neu;
			end
			if (c < 0) begin
				c = '0;
			end else if (c > TOP) begin
				c = TOP;
			end
			code_c[i] = c[owmm_pkg::CODE_WIDTH-1:0];
		end
		res_c.motor_rear_right = code_c[0];
		res_c.motor_front_right = code_c[1];
		res_c.motor_rear_left = code_c[2];
		res_c.motor_front_left = code_c[3];
	end

	// Output register: takes a new result when empty or when the current one is taken.
	assign en8 = !v_s8 || out_ready;
	assign in_ready = en8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en8) begin
			v_s8 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			res_s8 <= res_c;
			op_s8 <= side.op;
		end
	end

	assign out_valid = v_s8;
	assign res = res_s8;

	// A stop result drives the same code on every wheel.
	a_stop_equal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && op_s8 == owmm_pkg::OP_STOP |->
			res_s8.motor_rear_right == res_s8.motor_front_right &&
			res_s8.motor_rear_right == res_s8.motor_rear_left &&
			res_s8.motor_rear_right == res_s8.motor_front_left)
		else $error("stop result with unequal wheel codes");

endmodule

@@ design/omni_wheel_motor_mixer_unit.sv @@
// Pipeline: eight register stages (two mixing, one multiply, four divider, one code); a
// command passes through them in order and its result ends in the output register.
// Throughput: one command per cycle unless res_ready holds the pipe; the four-stage
// divider, three quotient bits per stage, sets the depth. Velocity commands taken
// while halted yield no result. Reset (arst_n low, asynchronous) empties every stage
// and restores the register defaults; the block accepts commands once reset is released.
module omni_wheel_motor_mixer_unit #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  owmm_pkg::cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output owmm_pkg::res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [owmm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [owmm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int WW = FRAC_BITS + 3;
	localparam int AW = FRAC_BITS + 2;
	localparam int DW = FRAC_BITS + 3;
	localparam int NW = DW + owmm_pkg::QUO_W;

	logic [owmm_pkg::NEUTRAL_W-1:0] neutral_q;
	logic [owmm_pkg::GAIN_W-1:0] gain_q;
	logic [owmm_pkg::LIMIT_W-1:0] limit_q;
	logic [owmm_pkg::OFFSET_W-1:0] offset_q;
	logic halted_q;

	logic [owmm_pkg::LIMIT_W-1:0] lim_c;
	logic [owmm_pkg::GAIN_W+owmm_pkg::LIMIT_W-1:0] glim_full;
	owmm_pkg::cfg_t cfg;

	logic mix_valid, mix_ready, mix_op, mix_scale;
	logic [AW-1:0] mix_amp;
	logic signed [WW-1:0] mix_w [owmm_pkg::LANES];

	logic scl_valid, scl_ready;
	logic [NW-1:0] scl_num [owmm_pkg::LANES];
	logic [DW-1:0] scl_den;
	owmm_pkg::side_t scl_side;

	logic div_valid, div_ready;
	logic [owmm_pkg::QUO_W-1:0] div_quo [owmm_pkg::LANES];
	owmm_pkg::side_t div_side;

	// Configuration registers; writes beyond the register list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_q <= owmm_pkg::NEUTRAL_RESET;
			gain_q <= owmm_pkg::GAIN_RESET;
			limit_q <= owmm_pkg::LIMIT_RESET;
			offset_q <= owmm_pkg::OFFSET_RESET;
			halted_q <= owmm_pkg::HALT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (owmm_pkg::reg_index_t'(cfg_index))
				owmm_pkg::REG_NEUTRAL: neutral_q <= cfg_data[owmm_pkg::NEUTRAL_W-1:0];
				owmm_pkg::REG_GAIN: gain_q <= cfg_data[owmm_pkg::GAIN_W-1:0];
				owmm_pkg::REG_LIMIT: limit_q <= cfg_data[owmm_pkg::LIMIT_W-1:0];
				owmm_pkg::REG_OFFSET: offset_q <= cfg_data[owmm_pkg::OFFSET_W-1:0];
				owmm_pkg::REG_HALT: halted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Limit brought into range and the code span gain times limit.
	always_comb begin
		if (limit_q < owmm_pkg::LIMIT_MIN) begin
			lim_c = owmm_pkg::LIMIT_MIN;
		end else if (limit_q > owmm_pkg::LIMIT_MAX) begin
			lim_c = owmm_pkg::LIMIT_MAX;
		end else begin
			lim_c = limit_q;
		end
		glim_full = gain_q * lim_c;
		cfg.neutral = neutral_q;
		cfg.gain = gain_q;
		cfg.limit = lim_c;
		cfg.offset = offset_q;
		cfg.glim = glim_full[owmm_pkg::GLIM_W-1:0];
		cfg.halted = halted_q;
	end

	owmm_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(cmd_valid),
		.in_ready(cmd_ready),
		.cmd(cmd),
		.out_valid(mix_valid),
		.out_ready(mix_ready),
		.op(mix_op),
		.scale(mix_scale),
		.amp(mix_amp),
		.w(mix_w)
	);

	owmm_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(mix_valid),
		.in_ready(mix_ready),
		.op(mix_op),
		.scale(mix_scale),
		.amp(mix_amp),
		.w(mix_w),
		.out_valid(scl_valid),
		.out_ready(scl_ready),
		.num(scl_num),
		.den(scl_den),
		.side(scl_side)
	);

	owmm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(scl_valid),
		.in_ready(scl_ready),
		.num(scl_num),
		.den(scl_den),
		.side_in(scl_side),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.quo(div_quo),
		.side_out(div_side)
	);

	owmm_code u_code (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(div_valid),
		.in_ready(div_ready),
		.quo(div_quo),
		.side(div_side),
		.out_valid(res_valid),
		.out_ready(res_ready),
		.res(res)
	);

endmodule
